@@ hw/rtl/container_stream_deframer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the container stream deframer
// Shared property forms used by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef CONTAINER_STREAM_DEFRAMER_UNIT_ASSERT_SVH
`define CONTAINER_STREAM_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CDF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cdf_pkg.sv @@
// ----------------------------------------------------------------------------
// cdf_pkg
// Region codes, marker constants and the result beat type of the deframer.
// ----------------------------------------------------------------------------
package cdf_pkg;

	typedef logic [3:0] cdf_region_t;

	localparam cdf_region_t RG_IDENT       = 4'd0;
	localparam cdf_region_t RG_VERSION     = 4'd1;
	localparam cdf_region_t RG_CODING      = 4'd2;
	localparam cdf_region_t RG_SIZE        = 4'd3;
	localparam cdf_region_t RG_COUNT       = 4'd4;
	localparam cdf_region_t RG_TITLE_LEN   = 4'd5;
	localparam cdf_region_t RG_TITLE       = 4'd6;
	localparam cdf_region_t RG_TYPE        = 4'd7;
	localparam cdf_region_t RG_NAME_LEN    = 4'd8;
	localparam cdf_region_t RG_NAME        = 4'd9;
	localparam cdf_region_t RG_CONTENT_LEN = 4'd10;
	localparam cdf_region_t RG_CONTENT     = 4'd11;
	localparam cdf_region_t RG_TRAILING    = 4'd12;

	localparam logic [7:0]  MARK_TYPE      = 8'd2;
	localparam logic [31:0] MARK_LEN_LIMIT = 32'd10;

	localparam logic [7:0] MARK_CH0 = 8'h23; // '#'
	localparam logic [7:0] MARK_CH1 = 8'h50; // 'P'
	localparam logic [7:0] MARK_CH2 = 8'h5F; // '_'

	localparam logic [1:0] MM_NONE = 2'd0;
	localparam logic [1:0] MM_HASH = 2'd1;
	localparam logic [1:0] MM_P    = 2'd2;

	typedef struct packed {
		cdf_region_t region;
		logic [7:0]  byte_out;
		logic [15:0] record_index;
		logic [31:0] field_value;
		logic        field_complete;
		logic        record_done;
		logic        param_entry;
		logic        all_done;
	} cdf_result_t;

endpackage

@@ hw/rtl/cdf_in_if.sv @@
// ----------------------------------------------------------------------------
// cdf_in_if
// Byte input channel of the deframer: valid/ready, the raw byte and a start-of-file flag.
// ----------------------------------------------------------------------------
interface cdf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;

	modport source (output valid, output data_byte, output start_of_file, input ready);
	modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

@@ hw/rtl/cdf_out_if.sv @@
// ----------------------------------------------------------------------------
// cdf_out_if
// Labeled byte output channel of the deframer.
// ----------------------------------------------------------------------------
interface cdf_out_if;
	logic                valid;
	logic                ready;
	cdf_pkg::cdf_region_t region;
	logic [7:0]          byte_out;
	logic [15:0]         record_index;
	logic [31:0]         field_value;
	logic                field_complete;
	logic                record_done;
	logic                param_entry;
	logic                all_done;

	modport source (output valid, output region, output byte_out, output record_index,
		output field_value, output field_complete, output record_done,
		output param_entry, output all_done, input ready);
	modport sink (input valid, input region, input byte_out, input record_index,
		input field_value, input field_complete, input record_done,
		input param_entry, input all_done, output ready);
endinterface

@@ hw/rtl/container_stream_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// container_stream_deframer_unit
// Labels each byte of a container stream with its header/record region.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one raw byte per beat; start_of_file=1 restarts the parser at
//            the identification field before that byte is parsed.
//   out_ch : one labeled beat per input beat, in order: region, the byte,
//            record index, numeric field value, and the field/record/done
//            flags (param_entry marks a type-2 record with short content
//            holding "#P_").
//   Throughput: one byte per cycle while in_ch.ready is high; the parse state
//            is updated by a single 32-bit shift/add/decrement stage per byte.
//   Reset   : arst_n clears the parse state to the identification field and
//            empties the output stage; in_ch.ready is high right after.
//   Stall   : an output register plus one skid entry hold results; in_ch.ready
//            drops only while both are full, and no beat is lost.
// ----------------------------------------------------------------------------
module container_stream_deframer_unit (
	input  logic         clk,
	input  logic         arst_n,
	cdf_in_if.sink       in_ch,
	cdf_out_if.source    out_ch
);

	// parse state
	cdf_pkg::cdf_region_t region_q;
	logic [31:0] left_q;
	logic [31:0] acc_q;
	logic [15:0] recs_left_q;
	logic [15:0] cur_rec_q;
	logic        type_mark_q;
	logic        len_small_q;
	logic [1:0]  mmatch_q;
	logic        mfound_q;

	// next values
	cdf_pkg::cdf_region_t region_d;
	logic [31:0] left_d;
	logic [31:0] acc_d;
	logic [15:0] recs_left_d;
	logic [15:0] cur_rec_d;
	logic        type_mark_d;
	logic        len_small_d;
	logic [1:0]  mmatch_d;
	logic        mfound_d;

	// state after optional restart
	cdf_pkg::cdf_region_t region_c;
	cdf_pkg::cdf_region_t r;
	logic [31:0] left_c;
	logic [31:0] acc_c;
	logic [15:0] recs_left_c;
	logic [15:0] cur_rec_c;
	logic        type_mark_c;
	logic        len_small_c;
	logic [1:0]  mmatch_c;
	logic        mfound_c;

	logic [31:0] num_acc;
	logic [31:0] num_cnt;
	logic [31:0] left_dec;
	logic [31:0] num_size;
	logic [15:0] recs_for_begin;
	logic        do_end;
	logic        do_begin;
	logic [7:0]  b;

	cdf_pkg::cdf_result_t res;

	// output stage
	cdf_pkg::cdf_result_t out_data_q;
	cdf_pkg::cdf_result_t skid_data_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic in_acc;
	logic out_take;

	assign in_ch.ready = !skid_valid_q;
	assign in_acc      = in_ch.valid && !skid_valid_q;
	assign out_take    = out_valid_q && out_ch.ready;
	assign b           = in_ch.data_byte;

	always_comb begin
		if (in_ch.start_of_file) begin
			region_c    = cdf_pkg::RG_IDENT;
			left_c      = '0;
			acc_c       = '0;
			recs_left_c = '0;
			cur_rec_c   = '0;
			type_mark_c = 1'b0;
			len_small_c = 1'b1;
			mmatch_c    = cdf_pkg::MM_NONE;
			mfound_c    = 1'b0;
		end else begin
			region_c    = region_q;
			left_c      = left_q;
			acc_c       = acc_q;
			recs_left_c = recs_left_q;
			cur_rec_c   = cur_rec_q;
			type_mark_c = type_mark_q;
			len_small_c = len_small_q;
			mmatch_c    = mmatch_q;
			mfound_c    = mfound_q;
		end
	end

	always_comb begin
		r = (region_c > cdf_pkg::RG_TRAILING) ? cdf_pkg::RG_TRAILING : region_c;

		region_d    = region_c;
		left_d      = left_c;
		acc_d       = acc_c;
		recs_left_d = recs_left_c;
		cur_rec_d   = cur_rec_c;
		type_mark_d = type_mark_c;
		len_small_d = len_small_c;
		mmatch_d    = mmatch_c;
		mfound_d    = mfound_c;

		num_acc  = {acc_c[23:0], b};
		num_cnt  = left_c + 32'd1;
		left_dec = left_c - 32'd1;
		if (r == cdf_pkg::RG_SIZE || r == cdf_pkg::RG_CONTENT_LEN) begin
			num_size = 32'd4;
		end else if (r == cdf_pkg::RG_COUNT) begin
			num_size = 32'd2;
		end else begin
			num_size = 32'd1;
		end

		do_end         = 1'b0;
		do_begin       = 1'b0;
		recs_for_begin = recs_left_c;

		res                = '0;
		res.region         = r;
		res.byte_out       = b;
		if (r >= cdf_pkg::RG_TYPE && r <= cdf_pkg::RG_CONTENT) begin
			res.record_index = cur_rec_c;
		end

		case (r)
			cdf_pkg::RG_TITLE, cdf_pkg::RG_NAME, cdf_pkg::RG_CONTENT: begin
				if (r == cdf_pkg::RG_CONTENT) begin
					if (b == cdf_pkg::MARK_CH0) begin
						mmatch_d = cdf_pkg::MM_HASH;
					end else if (mmatch_c == cdf_pkg::MM_HASH && b == cdf_pkg::MARK_CH1) begin
						mmatch_d = cdf_pkg::MM_P;
					end else if (mmatch_c == cdf_pkg::MM_P && b == cdf_pkg::MARK_CH2) begin
						mmatch_d = cdf_pkg::MM_NONE;
						mfound_d = 1'b1;
					end else begin
						mmatch_d = cdf_pkg::MM_NONE;
					end
				end
				left_d = left_dec;
				if (left_dec == 32'd0) begin
					if (r == cdf_pkg::RG_TITLE) begin
						do_begin = 1'b1;
					end else if (r == cdf_pkg::RG_NAME) begin
						region_d = cdf_pkg::RG_CONTENT_LEN;
						left_d   = '0;
						acc_d    = '0;
					end else begin
						do_end = 1'b1;
					end
				end
			end
			cdf_pkg::RG_TRAILING: begin
				region_d     = cdf_pkg::RG_TRAILING;
				res.all_done = 1'b1;
			end
			default: begin
				acc_d           = num_acc;
				left_d          = num_cnt;
				res.field_value = num_acc;
				if (num_cnt >= num_size) begin
					res.field_complete = 1'b1;
					left_d = '0;
					acc_d  = '0;
					case (r)
						cdf_pkg::RG_IDENT:   region_d = cdf_pkg::RG_VERSION;
						cdf_pkg::RG_VERSION: region_d = cdf_pkg::RG_CODING;
						cdf_pkg::RG_CODING:  region_d = cdf_pkg::RG_SIZE;
						cdf_pkg::RG_SIZE:    region_d = cdf_pkg::RG_COUNT;
						cdf_pkg::RG_COUNT: begin
							recs_left_d = num_acc[15:0];
							region_d    = cdf_pkg::RG_TITLE_LEN;
						end
						cdf_pkg::RG_TITLE_LEN: begin
							if (num_acc == 32'd0) begin
								do_begin = 1'b1;
							end else begin
								region_d = cdf_pkg::RG_TITLE;
								left_d   = num_acc;
							end
						end
						cdf_pkg::RG_TYPE: begin
							type_mark_d = (b == cdf_pkg::MARK_TYPE);
							region_d    = cdf_pkg::RG_NAME_LEN;
						end
						cdf_pkg::RG_NAME_LEN: begin
							if (num_acc == 32'd0) begin
								region_d = cdf_pkg::RG_CONTENT_LEN;
							end else begin
								region_d = cdf_pkg::RG_NAME;
								left_d   = num_acc;
							end
						end
						default: begin
							len_small_d = (num_acc < cdf_pkg::MARK_LEN_LIMIT);
							mmatch_d    = cdf_pkg::MM_NONE;
							mfound_d    = 1'b0;
							if (num_acc == 32'd0) begin
								do_end = 1'b1;
							end else begin
								region_d = cdf_pkg::RG_CONTENT;
								left_d   = num_acc;
							end
						end
					endcase
				end
			end
		endcase

		if (do_end) begin
			res.record_done = 1'b1;
			res.param_entry = type_mark_d && len_small_d && mfound_d;
			recs_left_d     = recs_left_c - 16'd1;
			cur_rec_d       = cur_rec_c + 16'd1;
			recs_for_begin  = recs_left_c - 16'd1;
			do_begin        = 1'b1;
		end

		if (do_begin) begin
			left_d = '0;
			acc_d  = '0;
			if (recs_for_begin == 16'd0) begin
				region_d     = cdf_pkg::RG_TRAILING;
				res.all_done = 1'b1;
			end else begin
				region_d    = cdf_pkg::RG_TYPE;
				type_mark_d = 1'b0;
				len_small_d = 1'b1;
				mmatch_d    = cdf_pkg::MM_NONE;
				mfound_d    = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q    <= cdf_pkg::RG_IDENT;
			left_q      <= '0;
			acc_q       <= '0;
			recs_left_q <= '0;
			cur_rec_q   <= '0;
			type_mark_q <= 1'b0;
			len_small_q <= 1'b1;
			mmatch_q    <= cdf_pkg::MM_NONE;
			mfound_q    <= 1'b0;
		end else if (in_acc) begin
			region_q    <= region_d;
			left_q      <= left_d;
			acc_q       <= acc_d;
			recs_left_q <= recs_left_d;
			cur_rec_q   <= cur_rec_d;
			type_mark_q <= type_mark_d;
			len_small_q <= len_small_d;
			mmatch_q    <= mmatch_d;
			mfound_q    <= mfound_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_acc) begin
				out_data_q <= res;
			end
		end else if (in_acc) begin
			skid_data_q <= res;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.region         = out_data_q.region;
	assign out_ch.byte_out       = out_data_q.byte_out;
	assign out_ch.record_index   = out_data_q.record_index;
	assign out_ch.field_value    = out_data_q.field_value;
	assign out_ch.field_complete = out_data_q.field_complete;
	assign out_ch.record_done    = out_data_q.record_done;
	assign out_ch.param_entry    = out_data_q.param_entry;
	assign out_ch.all_done       = out_data_q.all_done;

endmodule

@@ hw/rtl/cdf_checker.sv @@
// ----------------------------------------------------------------------------
// cdf_checker
// Port-level checks on the deframer output beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "container_stream_deframer_unit_assert.svh"

module cdf_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input cdf_pkg::cdf_region_t region,
	input logic [7:0]           byte_out,
	input logic                 field_complete,
	input logic                 record_done,
	input logic                 param_entry,
	input logic                 all_done
);

	`CDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(region) && $stable(byte_out), "output beat changed while stalled")

	`CDF_ASSERT_NOW(a_param_in_done, out_valid && param_entry, record_done, "param_entry without record_done")

	`CDF_ASSERT_NOW(a_trailing_done, out_valid && region == cdf_pkg::RG_TRAILING, all_done, "trailing byte without all_done")

	`CDF_ASSERT_NOW(a_done_region, out_valid && record_done, region == cdf_pkg::RG_CONTENT || region == cdf_pkg::RG_CONTENT_LEN, "record ended outside content")

	`CDF_ASSERT_NOW(a_complete_numeric, out_valid && field_complete, region != cdf_pkg::RG_TITLE && region != cdf_pkg::RG_NAME && region != cdf_pkg::RG_CONTENT && region != cdf_pkg::RG_TRAILING, "field_complete on a non-numeric byte")

endmodule

bind container_stream_deframer_unit cdf_checker u_cdf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.region         (out_ch.region),
	.byte_out       (out_ch.byte_out),
	.field_complete (out_ch.field_complete),
	.record_done    (out_ch.record_done),
	.param_entry    (out_ch.param_entry),
	.all_done       (out_ch.all_done)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds container streams (short directed files, then random well-formed,
// truncated and noise files) through the deframer with random idling on
// both channels, and checks every labeled beat against a byte-level model
// of the header/record parser.
// ----------------------------------------------------------------------------
module tb_top;

	// Parser model plus the queue of labels still owed by the block.
	class deframe_scoreboard;
		cdf_pkg::cdf_region_t region_q;
		logic [31:0] count_q;       // numeric: bytes taken; data fields: bytes left
		logic [31:0] acc_q;
		logic [15:0] recs_left_q;
		logic [15:0] rec_idx_q;
		logic [7:0]  rec_type_q;
		logic [31:0] content_len_q;
		logic [1:0]  marker_q;
		logic        marker_hit_q;
		cdf_pkg::cdf_result_t label;
		cdf_pkg::cdf_result_t pending_labels[$];
		int          errors;

		function new();
			clear_state();
			errors = 0;
		endfunction

		function void clear_state();
			region_q = cdf_pkg::RG_IDENT;
			count_q = '0;
			acc_q = '0;
			recs_left_q = '0;
			rec_idx_q = '0;
			rec_type_q = '0;
			content_len_q = '0;
			marker_q = cdf_pkg::MM_NONE;
			marker_hit_q = 1'b0;
		endfunction

		function void enter_region(cdf_pkg::cdf_region_t r, logic [31:0] left);
			region_q = r;
			count_q = left;
			acc_q = '0;
		endfunction

		function void next_record_or_finish();
			if (recs_left_q == 0) begin
				enter_region(cdf_pkg::RG_TRAILING, '0);
				label.all_done = 1'b1;
			end else begin
				rec_type_q = '0;
				content_len_q = '0;
				marker_q = cdf_pkg::MM_NONE;
				marker_hit_q = 1'b0;
				enter_region(cdf_pkg::RG_TYPE, '0);
			end
		endfunction

		function void close_record();
			label.record_done = 1'b1;
			label.param_entry = (rec_type_q == cdf_pkg::MARK_TYPE)
				&& (content_len_q < cdf_pkg::MARK_LEN_LIMIT) && marker_hit_q;
			recs_left_q = recs_left_q - 16'd1;
			rec_idx_q = rec_idx_q + 16'd1;
			next_record_or_finish();
		endfunction

		function void scan_marker(logic [7:0] b);
			if (b == cdf_pkg::MARK_CH0) begin
				marker_q = cdf_pkg::MM_HASH;
			end else if (marker_q == cdf_pkg::MM_HASH && b == cdf_pkg::MARK_CH1) begin
				marker_q = cdf_pkg::MM_P;
			end else if (marker_q == cdf_pkg::MM_P && b == cdf_pkg::MARK_CH2) begin
				marker_hit_q = 1'b1;
				marker_q = cdf_pkg::MM_NONE;
			end else begin
				marker_q = cdf_pkg::MM_NONE;
			end
		endfunction

		function logic [31:0] field_width(cdf_pkg::cdf_region_t r);
			if (r == cdf_pkg::RG_SIZE || r == cdf_pkg::RG_CONTENT_LEN)
				return 32'd4;
			if (r == cdf_pkg::RG_COUNT)
				return 32'd2;
			return 32'd1;
		endfunction

		// called once per accepted input beat
		function void label_byte(logic [7:0] b, logic sof);
			cdf_pkg::cdf_region_t r;
			if (sof)
				clear_state();
			label = '0;
			r = (region_q > cdf_pkg::RG_TRAILING) ? cdf_pkg::RG_TRAILING : region_q;
			label.region = r;
			label.byte_out = b;
			if (r >= cdf_pkg::RG_TYPE && r <= cdf_pkg::RG_CONTENT)
				label.record_index = rec_idx_q;
			if (r == cdf_pkg::RG_TITLE || r == cdf_pkg::RG_NAME || r == cdf_pkg::RG_CONTENT) begin
				if (r == cdf_pkg::RG_CONTENT)
					scan_marker(b);
				count_q = count_q - 32'd1;
				if (count_q == 0) begin
					if (r == cdf_pkg::RG_TITLE)
						next_record_or_finish();
					else if (r == cdf_pkg::RG_NAME)
						enter_region(cdf_pkg::RG_CONTENT_LEN, '0);
					else
						close_record();
				end
			end else if (r == cdf_pkg::RG_TRAILING) begin
				region_q = cdf_pkg::RG_TRAILING;
				label.all_done = 1'b1;
			end else begin
				acc_q = {acc_q[23:0], b};
				count_q = count_q + 32'd1;
				label.field_value = acc_q;
				if (count_q >= field_width(r)) begin
					label.field_complete = 1'b1;
					case (r)
						cdf_pkg::RG_IDENT: enter_region(cdf_pkg::RG_VERSION, '0);
						cdf_pkg::RG_VERSION: enter_region(cdf_pkg::RG_CODING, '0);
						cdf_pkg::RG_CODING: enter_region(cdf_pkg::RG_SIZE, '0);
						cdf_pkg::RG_SIZE: enter_region(cdf_pkg::RG_COUNT, '0);
						cdf_pkg::RG_COUNT: begin
							recs_left_q = acc_q[15:0];
							enter_region(cdf_pkg::RG_TITLE_LEN, '0);
						end
						cdf_pkg::RG_TITLE_LEN: begin
							if (acc_q == 0)
								next_record_or_finish();
							else
								enter_region(cdf_pkg::RG_TITLE, acc_q);
						end
						cdf_pkg::RG_TYPE: begin
							rec_type_q = b;
							enter_region(cdf_pkg::RG_NAME_LEN, '0);
						end
						cdf_pkg::RG_NAME_LEN: begin
							if (acc_q == 0)
								enter_region(cdf_pkg::RG_CONTENT_LEN, '0);
							else
								enter_region(cdf_pkg::RG_NAME, acc_q);
						end
						default: begin
							content_len_q = acc_q;
							marker_q = cdf_pkg::MM_NONE;
							marker_hit_q = 1'b0;
							if (acc_q == 0)
								close_record();
							else
								enter_region(cdf_pkg::RG_CONTENT, acc_q);
						end
					endcase
				end
			end
			pending_labels.insert(pending_labels.size(), label);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_beat(cdf_pkg::cdf_result_t got);
			cdf_pkg::cdf_result_t want;
			if (pending_labels.size() == 0) begin
				$error("output beat with nothing pending: region %0d byte %02h",
					got.region, got.byte_out);
				errors++;
				return;
			end
			want = pending_labels.pop_front();
			compare_field("region", want.region, got.region);
			compare_field("byte_out", want.byte_out, got.byte_out);
			compare_field("record_index", want.record_index, got.record_index);
			compare_field("field_value", want.field_value, got.field_value);
			compare_field("field_complete", want.field_complete, got.field_complete);
			compare_field("record_done", want.record_done, got.record_done);
			compare_field("param_entry", want.param_entry, got.param_entry);
			compare_field("all_done", want.all_done, got.all_done);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cdf_in_if  in_ch();
	cdf_out_if out_ch();

	container_stream_deframer_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	deframe_scoreboard sb;
	bit         calm;          // no idling on either side while set
	int         hold_asks;     // bumped by the sender to stall the receiver
	int         bytes_sent;
	logic [7:0] file_q[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400_000;
		$display("simulation failed");
		$finish;
	end

	function automatic void append_byte(input logic [7:0] b);
		file_q.insert(file_q.size(), b);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic sof);
		while (!calm && $urandom_range(99) < 17) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.start_of_file <= sof;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.label_byte(b, sof);
		bytes_sent++;
	endtask

	task automatic send_file(input bit restart);
		foreach (file_q[i])
			send_byte(file_q[i], restart && i == 0);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_labels.size() != 0);
	endtask

	function automatic logic [7:0] content_char();
		case ($urandom_range(5))
			0: return cdf_pkg::MARK_CH0;
			1: return cdf_pkg::MARK_CH1;
			2: return cdf_pkg::MARK_CH2;
			default: return 8'($urandom);
		endcase
	endfunction

	// Random container; huge record counts or content lengths leave the file cut short.
	task automatic build_container();
		logic [15:0] cnt;
		logic [7:0]  tlen;
		logic [7:0]  nlen;
		logic [31:0] clen;
		logic [7:0]  mark[3];
		int          n_rec;
		int          cbytes;
		int          mpos;
		bit          cut;
		mark = '{cdf_pkg::MARK_CH0, cdf_pkg::MARK_CH1, cdf_pkg::MARK_CH2};
		file_q.delete();
		repeat (7)
			append_byte(8'($urandom));
		cnt = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
		append_byte(cnt[15:8]);
		append_byte(cnt[7:0]);
		tlen = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
		append_byte(tlen);
		repeat (tlen)
			append_byte(8'($urandom));
		n_rec = (cnt > 6) ? $urandom_range(1, 6) : cnt;
		cut = (cnt > 6);
		for (int i = 0; i < n_rec; i++) begin
			append_byte($urandom_range(1) ? cdf_pkg::MARK_TYPE : 8'($urandom));
			nlen = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
			append_byte(nlen);
			repeat (nlen)
				append_byte(8'($urandom));
			case ($urandom_range(9))
				0: clen = $urandom;
				1: clen = '0;
				default: clen = $urandom_range(1, 12);
			endcase
			for (int k = 3; k >= 0; k--)
				append_byte(clen[8*k +: 8]);
			cbytes = clen;
			if (clen > 40) begin
				cut = 1'b1;
				cbytes = $urandom_range(0, 6);
			end
			mpos = (cbytes >= 3 && $urandom_range(1)) ? $urandom_range(0, cbytes - 3) : -1;
			for (int j = 0; j < cbytes; j++) begin
				if (mpos >= 0 && j >= mpos && j < mpos + 3)
					append_byte(mark[j - mpos]);
				else
					append_byte(content_char());
			end
			if (clen > 40)
				break;
		end
		if (!cut) begin
			repeat ($urandom_range(0, 3))
				append_byte(8'($urandom));
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int          hold_left;
		int          hold_seen;
		cdf_pkg::cdf_result_t got;
		hold_left = 0;
		hold_seen = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got = '{region: out_ch.region, byte_out: out_ch.byte_out,
					record_index: out_ch.record_index, field_value: out_ch.field_value,
					field_complete: out_ch.field_complete, record_done: out_ch.record_done,
					param_entry: out_ch.param_entry, all_done: out_ch.all_done};
				sb.check_beat(got);
			end
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = 64;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= calm || $urandom_range(99) >= 17;
			end
		end
	end

	initial begin
		int random_base;
		int file_no;
		sb = new();
		calm <= 1'b0;
		hold_asks <= 0;
		bytes_sent = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.start_of_file <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty header: zero record count and zero title, then a trailing beat
		file_q = '{8'h00, 8'hFF, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
			8'h23};
		send_file(1'b0);
		// one type-2 record with no name and zero content length
		file_q = '{8'h7F, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00,
			cdf_pkg::MARK_TYPE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_file(1'b1);

		random_base = bytes_sent;
		file_no = 0;
		while (bytes_sent - random_base < 1650) begin
			if (file_no == 5)
				hold_asks <= hold_asks + 1;
			if (file_no == 10 || file_no == 28)
				wait_drained();
			calm <= (file_no >= 18 && file_no < 24);
			case ($urandom_range(19))
				0, 1: begin
					// noise with stray restarts
					repeat ($urandom_range(4, 30))
						send_byte(8'($urandom), $urandom_range(7) == 0);
				end
				2, 3, 4: begin
					// file broken off at a random point
					build_container();
					repeat ($urandom_range(1, file_q.size() - 1))
						void'(file_q.pop_back());
					send_file(1'b1);
				end
				5: begin
					build_container();
					send_file(1'b0);
				end
				default: begin
					build_container();
					send_file(1'b1);
				end
			endcase
			file_no++;
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
